// ===== hw/rtl/pad_to_midi_note_mapper_core_macros.svh =====
// ----------------------------------------------------------------------------
// Pad to MIDI note mapper - assertion macros
// Concurrent assertion shorthands shared by the mapper RTL.
// ----------------------------------------------------------------------------
`ifndef PAD_TO_MIDI_NOTE_MAPPER_CORE_MACROS_SVH
`define PAD_TO_MIDI_NOTE_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PNM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PNM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pnm_pkg.sv =====
// ----------------------------------------------------------------------------
// pnm_pkg
// Types and constants shared by the pad to MIDI note mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pnm_pkg;

    // configuration register indexes
    localparam logic CFG_ROOT_NOTE = 1'b0;
    localparam logic CFG_FIXED_VEL = 1'b1;

    localparam logic [6:0] ROOT_NOTE_RST = 7'd48;

    // MIDI codes
    localparam logic [3:0] TYPE_NOTE_OFF  = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON   = 4'h9;
    localparam logic [3:0] CIN_NOTE_OFF   = 4'h8;
    localparam logic [3:0] CIN_NOTE_ON   = 4'h9;
    localparam logic [3:0] OUT_CABLE      = 4'd2;
    localparam logic [3:0] IN_CABLE       = 4'd0;
    localparam logic [6:0] VEL_CONSTANT   = 7'd100;

    // note = root + octave*12 + pad - 24, computed unsigned in 9 bits
    localparam logic [8:0] OCT_BIAS  = 9'd24;
    localparam logic [8:0] NOTE_TOP  = 9'd151;

    typedef struct packed {
        logic       command;
        logic [3:0] cable;
        logic [7:0] status;
        logic [6:0] key;
        logic [6:0] velocity;
        logic [3:0] octave;
        logic [3:0] track;
    } t_pkt;

    typedef struct packed {
        logic       handled;
        logic       out_valid;
        logic [3:0] out_cable;
        logic [3:0] out_cin;
        logic [7:0] out_status;
        logic [6:0] out_note;
        logic [6:0] out_velocity;
    } t_res;

    // update request to the per-pad store
    typedef struct packed {
        logic       clear_all;
        logic       note_on_we;
        logic       note_off_we;
        logic [6:0] note;
        logic [3:0] channel;
    } t_store_op;

endpackage

// ===== hw/rtl/pnm_in_if.sv =====
// ----------------------------------------------------------------------------
// pnm_in_if
// Input channel: MIDI packet or all-notes-off command beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pnm_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [3:0] cable;
    logic [7:0] status;
    logic [6:0] key;
    logic [6:0] velocity;
    logic [3:0] octave;
    logic [3:0] track;

    modport source (
        output valid, command, cable, status, key, velocity, octave, track,
        input  ready
    );
    modport sink (
        input  valid, command, cable, status, key, velocity, octave, track,
        output ready
    );
endinterface

// ===== hw/rtl/pnm_out_if.sv =====
// ----------------------------------------------------------------------------
// pnm_out_if
// Result channel: one mapper result beat per input beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pnm_out_if;
    logic       valid;
    logic       ready;
    logic       handled;
    logic       out_valid;
    logic [3:0] out_cable;
    logic [3:0] out_cin;
    logic [7:0] out_status;
    logic [6:0] out_note;
    logic [6:0] out_velocity;

    modport source (
        output valid, handled, out_valid, out_cable, out_cin, out_status, out_note,
               out_velocity,
        input  ready
    );
    modport sink (
        input  valid, handled, out_valid, out_cable, out_cin, out_status, out_note,
               out_velocity,
        output ready
    );
endinterface

// ===== hw/rtl/pnm_pad_store.sv =====
// ----------------------------------------------------------------------------
// pnm_pad_store
// Per-pad note, channel and held mark, one read/write index per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pnm_pad_store #(
    parameter int PAD_NUM = 32,
    parameter int IDX_W   = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IDX_W-1:0]   i_idx,
    input  pnm_pkg::t_store_op i_op,
    output logic [6:0]         o_note,
    output logic [3:0]         o_channel,
    output logic               o_held
);
    import pnm_pkg::*;

    logic [6:0]       r_note [PAD_NUM];
    logic [3:0]       r_chan [PAD_NUM];
    logic [PAD_NUM-1:0] r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            for (int i = 0; i < PAD_NUM; i++) begin
                r_note[i] <= '0;
                r_chan[i] <= '0;
            end
        end else begin
            if (i_op.clear_all) begin
                r_held <= '0;
            end else if (i_op.note_on_we) begin
                r_note[i_idx] <= i_op.note;
                r_chan[i_idx] <= i_op.channel;
                r_held[i_idx] <= 1'b1;
            end else if (i_op.note_off_we) begin
                r_held[i_idx] <= 1'b0;
            end
        end
    end

    assign o_note    = r_note[i_idx];
    assign o_channel = r_chan[i_idx];
    assign o_held    = r_held[i_idx];

endmodule

// ===== hw/rtl/pad_to_midi_note_mapper_core.sv =====
// ----------------------------------------------------------------------------
// pad_to_midi_note_mapper_core
// Maps pad-grid note packets to transposed note-on/note-off packets on cable 2.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | beat
//  ---------+-----+--------------------+-----------------------------------------
//  i_pkt    | in  | valid/ready        | command, cable, status, key, vel, ...
//  o_res    | out | valid/ready        | handled, out_valid, cable, cin, ...
//  i_cfg_*  | in  | write enable only  | register index, 7-bit data
//
//  One beat per cycle sustained while o_res.ready is high. A beat lands in the
//  input register, is mapped from there and written to the result register.
//  The per-pad store is read and updated while the beat is mapped, so the
//  next beat always sees the previous beat's update.
//  Reset clears valid flags, held marks, stored notes and channels; root is 48.
//  A stalled result holds; the input register still fills, then i_pkt.ready
//  drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pad_to_midi_note_mapper_core_macros.svh"

module pad_to_midi_note_mapper_core #(
    parameter int PAD_NUM       = 32,
    parameter int FIRST_PAD_KEY = 68
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    pnm_in_if.sink     i_pkt,
    pnm_out_if.source  o_res
);
    import pnm_pkg::*;

    localparam int IDX_W = (PAD_NUM > 1) ? $clog2(PAD_NUM) : 1;

    // ---------------- configuration ----------------
    logic [6:0] r_root_note;
    logic       r_fixed_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_note <= ROOT_NOTE_RST;
            r_fixed_vel <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROOT_NOTE: r_root_note <= i_cfg_data;
                CFG_FIXED_VEL: r_fixed_vel <= i_cfg_data[0];
                default:       r_root_note <= r_root_note;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic r_in_vld;
    t_pkt r_pkt;
    logic r_out_vld;
    t_res r_res;
    logic w_adv;       // beat in the input register moves to the result register
    logic w_in_ready;

    assign w_adv      = r_in_vld && (!r_out_vld || o_res.ready);
    assign w_in_ready = !r_in_vld || w_adv;
    assign i_pkt.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_ready) begin
            r_in_vld <= i_pkt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_pkt.valid) begin
            r_pkt <= '{command:  i_pkt.command,  cable:  i_pkt.cable,
                       status:   i_pkt.status,   key:    i_pkt.key,
                       velocity: i_pkt.velocity, octave: i_pkt.octave,
                       track:    i_pkt.track};
        end
    end

    // ---------------- mapping ----------------
    logic [7:0]       w_diff;
    logic             w_in_range;
    logic [IDX_W-1:0] w_idx;
    logic [3:0]       w_type;
    logic             w_type_on;
    logic             w_type_off;
    logic             w_consume;
    logic             w_note_on;
    logic [7:0]       w_oct12;
    logic [8:0]       w_sum;
    logic             w_map_ok;
    logic [6:0]       w_note;
    logic             w_send;
    logic [3:0]       w_off_ch;
    logic [6:0]       w_rd_note;
    logic [3:0]       w_rd_chan;
    logic             w_rd_held;
    t_store_op        w_op;
    t_res             n_res;

    // pad offset; only meaningful when the key is in the pad range
    assign w_diff     = {1'b0, r_pkt.key} - 8'(FIRST_PAD_KEY);
    assign w_in_range = ({1'b0, r_pkt.key} >= 8'(FIRST_PAD_KEY))
                        && ({1'b0, w_diff} < 9'(PAD_NUM));
    assign w_idx      = w_diff[IDX_W-1:0];

    assign w_type     = r_pkt.status[7:4];
    assign w_type_on  = (w_type == TYPE_NOTE_ON);
    assign w_type_off = (w_type == TYPE_NOTE_OFF);
    assign w_consume  = !r_pkt.command && (r_pkt.cable == IN_CABLE) && w_in_range
                        && (w_type_on || w_type_off);
    // note-on with zero velocity counts as note-off
    assign w_note_on  = w_type_on && (r_pkt.velocity != 7'd0);

    // root + (octave-2)*12 + pad, biased by +24 to stay unsigned
    assign w_oct12  = {1'b0, r_pkt.octave, 3'b000} + {2'b00, r_pkt.octave, 2'b00};
    assign w_sum    = {2'b00, r_root_note} + {1'b0, w_oct12} + {2'b00, w_diff[6:0]};
    assign w_map_ok = (w_sum >= OCT_BIAS) && (w_sum <= NOTE_TOP);

    assign w_note   = w_note_on ? 7'(w_sum - OCT_BIAS) : w_rd_note;
    assign w_send   = w_consume && (!w_note_on || w_map_ok);
    assign w_off_ch = w_rd_held ? w_rd_chan : r_pkt.track;

    always_comb begin
        n_res = '0;
        n_res.handled = w_consume;
        if (w_send) begin
            n_res.out_valid = 1'b1;
            n_res.out_cable = OUT_CABLE;
            n_res.out_note  = w_note;
            if (w_note_on) begin
                n_res.out_cin      = CIN_NOTE_ON;
                n_res.out_status   = {TYPE_NOTE_ON, r_pkt.track};
                n_res.out_velocity = r_fixed_vel ? VEL_CONSTANT : r_pkt.velocity;
            end else begin
                n_res.out_cin    = CIN_NOTE_OFF;
                n_res.out_status = {TYPE_NOTE_OFF, w_off_ch};
            end
        end
    end

    always_comb begin
        w_op             = '0;
        w_op.clear_all   = w_adv && r_pkt.command;
        w_op.note_on_we  = w_adv && w_send && w_note_on;
        w_op.note_off_we = w_adv && w_send && !w_note_on;
        w_op.note        = w_note;
        w_op.channel     = r_pkt.track;
    end

    pnm_pad_store #(
        .PAD_NUM (PAD_NUM),
        .IDX_W   (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_idx     (w_idx),
        .i_op      (w_op),
        .o_note    (w_rd_note),
        .o_channel (w_rd_chan),
        .o_held    (w_rd_held)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.handled      = r_res.handled;
    assign o_res.out_valid    = r_res.out_valid;
    assign o_res.out_cable    = r_res.out_cable;
    assign o_res.out_cin      = r_res.out_cin;
    assign o_res.out_status   = r_res.out_status;
    assign o_res.out_note     = r_res.out_note;
    assign o_res.out_velocity = r_res.out_velocity;

    // ---------------- assertions ----------------
    `PNM_ASSERT_IMP(a_ready_when_out_free, i_clk, i_rst_n, !r_out_vld, w_in_ready, "input stalled with result register free")
    `PNM_ASSERT_IMP(a_sent_implies_handled, i_clk, i_rst_n, r_out_vld && r_res.out_valid, r_res.handled && (r_res.out_cable == OUT_CABLE), "packet sent without being handled")
    `PNM_ASSERT_NXT(a_clear_drops_held, i_clk, i_rst_n, w_op.clear_all, !w_rd_held, "held mark survived all-notes-off")
    `PNM_ASSERT_NXT(a_adv_fills_result, i_clk, i_rst_n, w_adv, r_out_vld, "advanced beat missing from result register")

endmodule
